// ===== sv/mmdd_pkg.sv =====
package mmdd_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_SIZE_DEF      = 1024;
  localparam int ELEMENT_WIDTH_DEF = 32;

  // Size register width is fixed by the register map
  localparam int CFG_W = 11;

  // Queue depths (powers of two)
  localparam int ITEM_QUEUE_DEPTH   = 4;
  localparam int RESULT_QUEUE_DEPTH = 2;

  // Position flags attached to each element by the front end
  typedef struct packed {
    logic col_first;   // column zero
    logic row_first;   // row zero
    logic mat_last;    // last element of the matrix
    logic size_one;    // matrix is 1x1
  } mmdd_tag_t;

  localparam int TAG_W = $bits(mmdd_tag_t);

endpackage

// ===== sv/mmdd_fifo.sv =====
module mmdd_fifo
  import mmdd_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] store [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [PW:0]      count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == (PW+1)'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      store[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== sv/mmdd_front.sv =====
module mmdd_front
  import mmdd_pkg::*;
#(
  parameter int MAX_SIZE      = MAX_SIZE_DEF,
  parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        push,
  input  logic [ELEMENT_WIDTH-1:0]                    element_value,
  input  logic                                        cfg_valid,
  input  logic [CFG_W-1:0]                            cfg_data,
  input  logic                                        queue_full,
  output logic                                        queue_push,
  output logic [ELEMENT_WIDTH+$clog2(MAX_SIZE)+TAG_W-1:0] queue_data,
  output logic                                        restart
);

  localparam int CW = $clog2(MAX_SIZE);

  logic [CW-1:0] col;
  logic [CW-1:0] row;
  logic [CW-1:0] last_idx;
  logic [CW-1:0] last_idx_next;
  logic [31:0]   size_ext;
  mmdd_tag_t     tag;

  // Clamp the size: zero acts as one, oversize saturates
  assign size_ext = 32'(cfg_data);
  always_comb begin
    priority if (size_ext == 32'd0) begin
      last_idx_next = '0;
    end else if (size_ext > 32'(MAX_SIZE)) begin
      last_idx_next = CW'(MAX_SIZE - 1);
    end else begin
      last_idx_next = CW'(size_ext - 32'd1);
    end
  end

  assign tag.col_first = (col == '0);
  assign tag.row_first = (row == '0);
  assign tag.mat_last  = (col == last_idx) && (row == last_idx);
  assign tag.size_one  = (last_idx == '0);

  assign queue_push = push && !queue_full;
  assign queue_data = {element_value, col, tag};
  assign restart    = cfg_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      col      <= '0;
      row      <= '0;
      last_idx <= '0;
    end else if (cfg_valid) begin
      col      <= '0;
      row      <= '0;
      last_idx <= last_idx_next;
    end else if (queue_push) begin
      if (col == last_idx) begin
        col <= '0;
        row <= (row == last_idx) ? '0 : row + 1'b1;
      end else begin
        col <= col + 1'b1;
      end
    end
  end

endmodule

// ===== sv/mmdd_back.sv =====
module mmdd_back
  import mmdd_pkg::*;
#(
  parameter int MAX_SIZE      = MAX_SIZE_DEF,
  parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEF
) (
  input  logic                                            clk,
  input  logic                                            rst,
  input  logic                                            restart,
  input  logic [ELEMENT_WIDTH+$clog2(MAX_SIZE)+TAG_W-1:0] item_data,
  input  logic                                            item_empty,
  output logic                                            item_pop,
  input  logic                                            result_full,
  output logic                                            result_push,
  output logic [ELEMENT_WIDTH+1:0]                        result_data
);

  localparam int CW = $clog2(MAX_SIZE);
  localparam int EW = ELEMENT_WIDTH;

  // Line store of prefix minima, one entry per column
  logic [EW-1:0] line_mem [MAX_SIZE];

  logic signed [EW-1:0] item_value;
  logic [CW-1:0]        item_col;

  logic                 b_valid;
  logic signed [EW-1:0] b_value;
  logic [CW-1:0]        b_col;
  mmdd_tag_t            b_tag;
  logic signed [EW-1:0] up_min;

  logic signed [EW-1:0] row_min;
  logic signed [EW-1:0] row_min_next;
  logic signed [EW-1:0] prior_min;
  logic signed [EW:0]   best;
  logic signed [EW:0]   best_next;
  logic signed [EW:0]   cand;
  logic signed [EW-1:0] new_prefix;
  logic                 advance;

  localparam logic [EW:0] MOST_NEG = {1'b1, {EW{1'b0}}};

  assign item_value = $signed(item_data[TAG_W+CW +: EW]);
  assign item_col   = item_data[TAG_W +: CW];

  // Stall the work stage only when it holds a result and the result queue is full
  assign advance  = !b_valid || !b_tag.mat_last || !result_full;
  assign item_pop = advance && !item_empty;

  always_comb begin
    row_min_next = (b_tag.col_first || (b_value < row_min)) ? b_value : row_min;
    cand         = {b_value[EW-1], b_value} - {prior_min[EW-1], prior_min};
    best_next    = best;
    if (!b_tag.row_first && !b_tag.col_first && (cand > best)) begin
      best_next = cand;
    end
    if (b_tag.row_first) begin
      new_prefix = row_min_next;
    end else begin
      new_prefix = (up_min < row_min_next) ? up_min : row_min_next;
    end
  end

  assign result_push = advance && b_valid && b_tag.mat_last;
  assign result_data = b_tag.size_one ? {{(EW+1){1'b0}}, 1'b1} : {best_next, 1'b0};

  // Read the next column while the current one writes back
  always_ff @(posedge clk) begin
    if (item_pop) begin
      up_min <= $signed(line_mem[item_col]);
    end
    if (advance && b_valid) begin
      line_mem[b_col] <= new_prefix;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      b_value <= item_value;
      b_col   <= item_col;
      b_tag   <= item_data[TAG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid   <= 1'b0;
      row_min   <= '0;
      prior_min <= '0;
      best      <= MOST_NEG;
    end else begin
      if (advance) begin
        b_valid <= !item_empty;
      end
      if (advance && b_valid) begin
        row_min <= row_min_next;
        if (!b_tag.row_first) begin
          prior_min <= up_min;
        end
        best <= b_tag.mat_last ? MOST_NEG : best_next;
      end
      if (restart) begin
        best <= MOST_NEG;
      end
    end
  end

endmodule

// ===== sv/matrix_max_dominated_difference.sv =====
// Path: an element accepted at the input passes through the item queue, the work
//   stage and the result queue on its way to the result ports.
// Throughput: one element per cycle while not stalled, set by the single line-store
//   read and write per element; the result queue absorbs a stalled consumer.
// Reset: rst is synchronous, active high; queues empty, size set to one, line
//   store contents left as they are (row zero does not use the values it reads).
module matrix_max_dominated_difference
  import mmdd_pkg::*;
#(
  parameter int MAX_SIZE      = MAX_SIZE_DEF,
  parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // Element input, queue style
  input  logic                            push,
  output logic                            full,
  input  logic signed [ELEMENT_WIDTH-1:0] element_value,
  // Result output, queue style
  output logic                            empty,
  input  logic                            pop,
  output logic signed [ELEMENT_WIDTH:0]   max_difference,
  output logic                            no_pair,
  // Size register write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [CFG_W-1:0]                cfg_data
);

  localparam int CW     = $clog2(MAX_SIZE);
  localparam int ITEM_W = ELEMENT_WIDTH + CW + TAG_W;
  localparam int RES_W  = ELEMENT_WIDTH + 2;

  logic              q_push;
  logic [ITEM_W-1:0] q_wr_data;
  logic              q_full;
  logic              q_pop;
  logic [ITEM_W-1:0] q_rd_data;
  logic              q_empty;
  logic              restart;
  logic              r_push;
  logic [RES_W-1:0]  r_wr_data;
  logic              r_full;
  logic [RES_W-1:0]  r_rd_data;

  // Size register always ready; user sends configuration only when idle, unchecked
  assign cfg_ready = 1'b1;
  assign full      = q_full;

  // Front end: track row and column, tag each element with its position
  mmdd_front #(
    .MAX_SIZE      (MAX_SIZE),
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .element_value (element_value),
    .cfg_valid     (cfg_valid),
    .cfg_data      (cfg_data),
    .queue_full    (q_full),
    .queue_push    (q_push),
    .queue_data    (q_wr_data),
    .restart       (restart)
  );

  // Short queue decoupling the front end from the work stage
  mmdd_fifo #(
    .WIDTH (ITEM_W),
    .DEPTH (ITEM_QUEUE_DEPTH)
  ) u_item_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (q_wr_data),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_rd_data),
    .empty   (q_empty)
  );

  // Back end: line store of prefix minima, running row minimum, best difference
  mmdd_back #(
    .MAX_SIZE      (MAX_SIZE),
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .restart     (restart),
    .item_data   (q_rd_data),
    .item_empty  (q_empty),
    .item_pop    (q_pop),
    .result_full (r_full),
    .result_push (r_push),
    .result_data (r_wr_data)
  );

  // Result queue: hold finished transactions while the consumer stalls
  mmdd_fifo #(
    .WIDTH (RES_W),
    .DEPTH (RESULT_QUEUE_DEPTH)
  ) u_result_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (r_push),
    .wr_data (r_wr_data),
    .full    (r_full),
    .rd_en   (pop),
    .rd_data (r_rd_data),
    .empty   (empty)
  );

  assign max_difference = $signed(r_rd_data[RES_W-1:1]);
  assign no_pair        = r_rd_data[0];

endmodule
